### hdl/plu_pkg.sv
`default_nettype none
package plu_pkg;

    // Number of distortion-removal passes, each a pipeline segment of its own.
    localparam int ITERATIONS = 8;
    // Register stages of the pixel lift and of one distortion pass.
    localparam int LIFT_STAGES = 2;
    localparam int ITER_STAGES = 8;
    localparam int LATENCY = LIFT_STAGES + ITERATIONS * ITER_STAGES;

    // Configuration register indexes.
    localparam logic [3:0] REG_INV_FOCAL_X = 4'd0;
    localparam logic [3:0] REG_OFFSET_X    = 4'd1;
    localparam logic [3:0] REG_INV_FOCAL_Y = 4'd2;
    localparam logic [3:0] REG_OFFSET_Y    = 4'd3;
    localparam logic [3:0] REG_RADIAL_K1   = 4'd4;
    localparam logic [3:0] REG_RADIAL_K2   = 4'd5;
    localparam logic [3:0] REG_TANGENT_P1  = 4'd6;
    localparam logic [3:0] REG_TANGENT_P2  = 4'd7;

    localparam int FRAC = 28;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] ROUND_HALF = 64'sd134217728;

    // A Q4.28 value together with its clip flag.
    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    // Distortion coefficients shared by all passes.
    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } coef_t;

    // Clip a wide signed value to 32 bit signed.
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > S32_MAX)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end
        else if (v < S32_MIN)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = 32'(v);
        end
        return r;
    endfunction

    // Q4.28 product, rounded half up, then clipped.
    function automatic sat_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = 64'(a) * 64'(b);
        r = (p + ROUND_HALF) >>> FRAC;
        return sat32(r);
    endfunction

    function automatic sat_t qadd(input logic signed [31:0] a, input logic signed [31:0] b);
        return sat32(64'(a) + 64'(b));
    endfunction

    function automatic sat_t qsub(input logic signed [31:0] a, input logic signed [31:0] b);
        return sat32(64'(a) - 64'(b));
    endfunction

endpackage
`default_nettype wire

### hdl/plu_lift.sv
`default_nettype none
module plu_lift (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [15:0]        pixel_x,
    input  wire logic [15:0]        pixel_y,
    input  wire logic [31:0]        inv_focal_x,
    input  wire logic signed [31:0] offset_x,
    input  wire logic [31:0]        inv_focal_y,
    input  wire logic signed [31:0] offset_y,
    output logic                    out_valid,
    output logic signed [31:0]      xd,
    output logic signed [31:0]      yd,
    output logic                    ovf
);

    logic               v1_reg, v2_reg;
    logic [47:0]        px_reg, py_reg;
    logic signed [31:0] xd_reg, xd_next, yd_reg, yd_next;
    logic               ovf_reg, ovf_next;

    // Scale one axis: round Q12.36 to Q4.28, clip, then add the offset.
    function automatic plu_pkg::sat_t lift_axis(input logic [47:0] p,
                                                input logic signed [31:0] off);
        logic [48:0]   rs;
        logic [40:0]   r;
        plu_pkg::sat_t s;
        plu_pkg::sat_t a;
        rs = {1'b0, p} + 49'd128;
        r  = rs[48:8];
        if (r > 41'd2147483647)
        begin
            s.ovf = 1'b1;
            s.val = 32'sh7FFFFFFF;
        end
        else
        begin
            s.ovf = 1'b0;
            s.val = signed'(r[31:0]);
        end
        a = plu_pkg::qadd(s.val, off);
        a.ovf = a.ovf | s.ovf;
        return a;
    endfunction

    // Second stage: rounding, clipping and offset.
    always_comb
    begin
        plu_pkg::sat_t sx;
        plu_pkg::sat_t sy;
        sx = lift_axis(px_reg, offset_x);
        sy = lift_axis(py_reg, offset_y);
        xd_next  = sx.val;
        yd_next  = sy.val;
        ovf_next = sx.ovf | sy.ovf;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Payload: products first, then the lifted point.
    always_ff @(posedge clk)
    begin
        px_reg  <= 48'(pixel_x) * 48'(inv_focal_x);
        py_reg  <= 48'(pixel_y) * 48'(inv_focal_y);
        xd_reg  <= xd_next;
        yd_reg  <= yd_next;
        ovf_reg <= ovf_next;
    end

    assign out_valid = v2_reg;
    assign xd        = xd_reg;
    assign yd        = yd_reg;
    assign ovf       = ovf_reg;

endmodule
`default_nettype wire

### hdl/plu_iter.sv
`default_nettype none
module plu_iter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire plu_pkg::coef_t     coef,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic signed [31:0] in_xd,
    input  wire logic signed [31:0] in_yd,
    input  wire logic               in_ovf,
    output logic                    out_valid,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_xd,
    output logic signed [31:0]      out_yd,
    output logic                    out_ovf
);

    // Everything one pass carries from stage to stage.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] xd;
        logic signed [31:0] yd;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] xy;
        logic signed [31:0] r2;
        logic signed [31:0] dx2;
        logic signed [31:0] dy2;
        logic signed [31:0] r4;
        logic signed [31:0] kr2;
        logic signed [31:0] tsx;
        logic signed [31:0] tsy;
        logic signed [31:0] p1xy;
        logic signed [31:0] p2xy;
        logic signed [31:0] k2r4;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] rad;
        logic signed [31:0] xr;
        logic signed [31:0] yr;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               ovf;
    } iter_t;

    iter_t st_reg  [plu_pkg::ITER_STAGES];
    iter_t st_next [plu_pkg::ITER_STAGES];
    logic [plu_pkg::ITER_STAGES-1:0] vld_reg;

    // Stage logic: one row of products or sums per stage.
    always_comb
    begin
        plu_pkg::sat_t t;
        iter_t         n;

        // Squares and cross product.
        n     = '0;
        n.x   = in_x;
        n.y   = in_y;
        n.xd  = in_xd;
        n.yd  = in_yd;
        n.ovf = in_ovf;
        t = plu_pkg::qmul(in_x, in_x); n.x2 = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(in_y, in_y); n.y2 = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(in_x, in_y); n.xy = t.val; n.ovf = n.ovf | t.ovf;
        st_next[0] = n;

        // Radius squared and doubled squares.
        n = st_reg[0];
        t = plu_pkg::qadd(n.x2, n.y2); n.r2  = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.x2, n.x2); n.dx2 = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.y2, n.y2); n.dy2 = t.val; n.ovf = n.ovf | t.ovf;
        st_next[1] = n;

        // Fourth power, first radial term, tangential sums and products.
        n = st_reg[1];
        t = plu_pkg::qmul(n.r2, n.r2);      n.r4   = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(coef.k1, n.r2);   n.kr2  = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.r2, n.dx2);     n.tsx  = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.r2, n.dy2);     n.tsy  = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(coef.p1, n.xy);   n.p1xy = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(coef.p2, n.xy);   n.p2xy = t.val; n.ovf = n.ovf | t.ovf;
        st_next[2] = n;

        // Second radial term, tangential terms and their doubled cross terms.
        n = st_reg[2];
        t = plu_pkg::qmul(coef.k2, n.r4);    n.k2r4 = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(coef.p2, n.tsx);   n.tx   = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(coef.p1, n.tsy);   n.ty   = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.p1xy, n.p1xy);   n.p1xy = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.p2xy, n.p2xy);   n.p2xy = t.val; n.ovf = n.ovf | t.ovf;
        st_next[3] = n;

        // Radial factor.
        n = st_reg[3];
        t = plu_pkg::qadd(n.kr2, n.k2r4); n.rad = t.val; n.ovf = n.ovf | t.ovf;
        st_next[4] = n;

        // Radial displacement.
        n = st_reg[4];
        t = plu_pkg::qmul(n.x, n.rad); n.xr = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qmul(n.y, n.rad); n.yr = t.val; n.ovf = n.ovf | t.ovf;
        st_next[5] = n;

        // Total displacement.
        n = st_reg[5];
        t = plu_pkg::qadd(n.xr, n.p1xy); n.dx = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.dx, n.tx);   n.dx = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.yr, n.p2xy); n.dy = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qadd(n.dy, n.ty);   n.dy = t.val; n.ovf = n.ovf | t.ovf;
        st_next[6] = n;

        // New estimate of the undistorted point.
        n = st_reg[6];
        t = plu_pkg::qsub(n.xd, n.dx); n.x = t.val; n.ovf = n.ovf | t.ovf;
        t = plu_pkg::qsub(n.yd, n.dy); n.y = t.val; n.ovf = n.ovf | t.ovf;
        st_next[7] = n;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[plu_pkg::ITER_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < plu_pkg::ITER_STAGES; i++)
        begin
            st_reg[i] <= st_next[i];
        end
    end

    assign out_valid = vld_reg[plu_pkg::ITER_STAGES-1];
    assign out_x     = st_reg[plu_pkg::ITER_STAGES-1].x;
    assign out_y     = st_reg[plu_pkg::ITER_STAGES-1].y;
    assign out_xd    = st_reg[plu_pkg::ITER_STAGES-1].xd;
    assign out_yd    = st_reg[plu_pkg::ITER_STAGES-1].yd;
    assign out_ovf   = st_reg[plu_pkg::ITER_STAGES-1].ovf;

endmodule
`default_nettype wire

### hdl/pinhole_lift_undistort_unit.sv
// Lifts a Q12.4 pixel coordinate to an undistorted Q4.28 ray (z = 1 implied).
// Request channel: pixel_x and pixel_y are taken at a rising edge with start
// high and busy low. busy never rises, so a request may be issued every cycle.
// Result channel: ray_x, ray_y and overflow are valid for the one cycle that
// done is high; the ports read zero otherwise. The receiver cannot stall.
// From request to done a request passes through the pixel lift, then
// eight undistortion passes of eight register stages each. Throughput is one
// request per cycle, set by the fully unrolled pass pipeline.
// Configuration: cfg_index and cfg_data are written when cfg_valid and
// cfg_ready are both high; cfg_ready is always high. Indexes above seven are
// ignored. The user must change registers only while no request is in flight;
// the block does not enforce it. Reset (rst_n low) zeroes the configuration
// and drops every request in flight; no result follows for a dropped request.
`default_nettype none
module pinhole_lift_undistort_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        pixel_x,
    input  wire logic [15:0]        pixel_y,
    output logic                    done,
    output logic signed [31:0]      ray_x,
    output logic signed [31:0]      ray_y,
    output logic                    overflow,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic [31:0]         inv_focal_x_reg, inv_focal_y_reg;
    logic signed [31:0]  offset_x_reg, offset_y_reg;
    plu_pkg::coef_t      coef_reg;

    logic                        v_chain   [plu_pkg::ITERATIONS+1];
    logic signed [31:0]          x_chain   [plu_pkg::ITERATIONS+1];
    logic signed [31:0]          y_chain   [plu_pkg::ITERATIONS+1];
    logic signed [31:0]          xd_chain  [plu_pkg::ITERATIONS+1];
    logic signed [31:0]          yd_chain  [plu_pkg::ITERATIONS+1];
    logic                        ovf_chain [plu_pkg::ITERATIONS+1];

    logic accept;

    assign accept    = start & ~busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= '0;
            inv_focal_y_reg <= '0;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            coef_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                plu_pkg::REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data;
                plu_pkg::REG_OFFSET_X:    offset_x_reg    <= signed'(cfg_data);
                plu_pkg::REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data;
                plu_pkg::REG_OFFSET_Y:    offset_y_reg    <= signed'(cfg_data);
                plu_pkg::REG_RADIAL_K1:   coef_reg.k1     <= signed'(cfg_data);
                plu_pkg::REG_RADIAL_K2:   coef_reg.k2     <= signed'(cfg_data);
                plu_pkg::REG_TANGENT_P1:  coef_reg.p1     <= signed'(cfg_data);
                plu_pkg::REG_TANGENT_P2:  coef_reg.p2     <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Pixel to distorted normalized point.
    plu_lift u_lift (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .inv_focal_x (inv_focal_x_reg),
        .offset_x    (offset_x_reg),
        .inv_focal_y (inv_focal_y_reg),
        .offset_y    (offset_y_reg),
        .out_valid   (v_chain[0]),
        .xd          (xd_chain[0]),
        .yd          (yd_chain[0]),
        .ovf         (ovf_chain[0])
    );

    // The first pass starts from the distorted point itself.
    assign x_chain[0] = xd_chain[0];
    assign y_chain[0] = yd_chain[0];

    // Unrolled undistortion passes.
    for (genvar g = 0; g < plu_pkg::ITERATIONS; g++)
    begin : g_pass
        plu_iter u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef      (coef_reg),
            .in_valid  (v_chain[g]),
            .in_x      (x_chain[g]),
            .in_y      (y_chain[g]),
            .in_xd     (xd_chain[g]),
            .in_yd     (yd_chain[g]),
            .in_ovf    (ovf_chain[g]),
            .out_valid (v_chain[g+1]),
            .out_x     (x_chain[g+1]),
            .out_y     (y_chain[g+1]),
            .out_xd    (xd_chain[g+1]),
            .out_yd    (yd_chain[g+1]),
            .out_ovf   (ovf_chain[g+1])
        );
    end

    // Result ports read zero outside the done cycle.
    assign done     = v_chain[plu_pkg::ITERATIONS];
    assign ray_x    = done ? x_chain[plu_pkg::ITERATIONS] : '0;
    assign ray_y    = done ? y_chain[plu_pkg::ITERATIONS] : '0;
    assign overflow = done & ovf_chain[plu_pkg::ITERATIONS];

endmodule
`default_nettype wire

### hdl/plu_checker.sv
`default_nettype none
module plu_assertions (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [31:0] ray_x,
    input wire logic signed [31:0] ray_y,
    input wire logic               overflow,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready
);

    // Every result answers a request issued exactly the pipeline latency earlier.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, plu_pkg::LATENCY))
        else $error("result without a matching request");

    // Result ports are quiet outside the done cycle.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (ray_x == 32'sd0 && ray_y == 32'sd0 && !overflow))
        else $error("result ports active without done");

    // The block never holds off requests or configuration writes.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid |-> cfg_ready) and (start |-> !busy))
        else $error("request or configuration write held off");

endmodule

bind pinhole_lift_undistort_unit plu_assertions u_plu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .ray_x     (ray_x),
    .ray_y     (ray_y),
    .overflow  (overflow),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

### bench/plu_checker.sv
`default_nettype none
module plu_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [15:0]        pixel_x,
    input  wire logic [15:0]        pixel_y,
    input  wire logic               done,
    input  wire logic signed [31:0] ray_x,
    input  wire logic signed [31:0] ray_y,
    input  wire logic               overflow,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      mismatches,
    output int                      rays_pending,
    output int                      rays_checked,
    output int                      rays_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted ray.
    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               ovf;
    } ray_t;

    ray_t ray_queue[$];

    // Shadow copy of the calibration registers.
    logic [31:0]        ifx, ify;
    logic signed [31:0] offx, offy, k1, k2, p1, p2;

    // Set by any clipping step during one prediction.
    logic clip_seen;

    function automatic logic signed [31:0] clip(input longint v);
        if (v > 64'sd2147483647)
        begin
            clip_seen = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            clip_seen = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint prod;
        prod = longint'(a) * longint'(b) + (longint'(1) <<< 27);
        return clip(prod >>> 28);
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return clip(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return clip(longint'(a) - longint'(b));
    endfunction

    // Pixel coordinate scaled to the normalized plane, then shifted.
    function automatic logic signed [31:0] to_plane(input logic [15:0] pix,
                                                    input logic [31:0] inv,
                                                    input logic signed [31:0] off);
        longint unsigned scaled;
        logic signed [31:0] q;
        scaled = (longint'(pix) * longint'(inv) + 128) >> 8;
        if (scaled > 64'd2147483647)
        begin
            clip_seen = 1'b1;
            q = 32'sh7FFFFFFF;
        end
        else
            q = scaled[31:0];
        return fx_add(q, off);
    endfunction

    // Radial plus tangential lens displacement at one point.
    task automatic lens_shift(input logic signed [31:0] x, input logic signed [31:0] y,
                              output logic signed [31:0] sx, output logic signed [31:0] sy);
        logic signed [31:0] x2, y2, xy, r2, r4, rad, tx, ty;
        x2 = fx_mul(x, x);
        y2 = fx_mul(y, y);
        xy = fx_mul(x, y);
        r2 = fx_add(x2, y2);
        r4 = fx_mul(r2, r2);
        rad = fx_add(fx_mul(k1, r2), fx_mul(k2, r4));
        tx = fx_mul(p2, fx_add(r2, fx_add(x2, x2)));
        ty = fx_mul(p1, fx_add(r2, fx_add(y2, y2)));
        xy = fx_mul(p1, xy) ;
        sx = fx_add(fx_add(fx_mul(x, rad), fx_add(xy, xy)), tx);
        xy = fx_mul(p2, fx_mul(x, y));
        sy = fx_add(fx_add(fx_mul(y, rad), fx_add(xy, xy)), ty);
    endtask

    task automatic predict_ray(input logic [15:0] px, input logic [15:0] py,
                               output ray_t r);
        logic signed [31:0] dx, dy, ux, uy, sx, sy;
        clip_seen = 1'b0;
        dx = to_plane(px, ifx, offx);
        dy = to_plane(py, ify, offy);
        ux = dx;
        uy = dy;
        // Each pass subtracts the displacement seen at the current estimate.
        for (int i = 0; i < plu_pkg::ITERATIONS; i++)
        begin
            lens_shift(ux, uy, sx, sy);
            ux = fx_sub(dx, sx);
            uy = fx_sub(dy, sy);
        end
        r.rx = ux;
        r.ry = uy;
        r.ovf = clip_seen;
    endtask

    task automatic report(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Watch the configuration, request and result channels.
    always @(posedge clk or negedge rst_n)
    begin
        ray_t r;
        if (!rst_n)
        begin
            ifx = '0; ify = '0; offx = '0; offy = '0;
            k1 = '0; k2 = '0; p1 = '0; p2 = '0;
            ray_queue.delete();
            rays_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    plu_pkg::REG_INV_FOCAL_X: ifx = cfg_data;
                    plu_pkg::REG_OFFSET_X:    offx = cfg_data;
                    plu_pkg::REG_INV_FOCAL_Y: ify = cfg_data;
                    plu_pkg::REG_OFFSET_Y:    offy = cfg_data;
                    plu_pkg::REG_RADIAL_K1:   k1 = cfg_data;
                    plu_pkg::REG_RADIAL_K2:   k2 = cfg_data;
                    plu_pkg::REG_TANGENT_P1:  p1 = cfg_data;
                    plu_pkg::REG_TANGENT_P2:  p2 = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                predict_ray(pixel_x, pixel_y, r);
                ray_queue.push_back(r);
            end
            if (done)
            begin
                if (ray_queue.size() == 0)
                    report("result with no request waiting");
                else
                begin
                    r = ray_queue.pop_front();
                    rays_checked++;
                    if (r.ovf)
                        rays_clipped++;
                    if (ray_x !== r.rx)
                        report($sformatf("ray_x %h, want %h", ray_x, r.rx));
                    if (ray_y !== r.ry)
                        report($sformatf("ray_y %h, want %h", ray_y, r.ry));
                    if (overflow !== r.ovf)
                        report($sformatf("overflow %b, want %b", overflow, r.ovf));
                end
            end
            rays_pending = ray_queue.size();
        end
    end

    initial
    begin
        mismatches = 0;
        rays_pending = 0;
        rays_checked = 0;
        rays_clipped = 0;
    end
endmodule
`default_nettype wire

### bench/tb_pinhole_lift_undistort_unit.sv
`default_nettype none
module tb_pinhole_lift_undistort_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [15:0]        pixel_x = '0;
    logic [15:0]        pixel_y = '0;
    logic               done;
    logic signed [31:0] ray_x, ray_y;
    logic               overflow;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    int                 mismatches, rays_pending, rays_checked, rays_clipped;
    int                 idle_pct = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pinhole_lift_undistort_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
        .ray_x(ray_x), .ray_y(ray_y), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    plu_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
        .ray_x(ray_x), .ray_y(ray_y), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .rays_pending(rays_pending),
        .rays_checked(rays_checked), .rays_clipped(rays_clipped)
    );

    // Issue one pixel request, with random idle cycles ahead of it.
    task automatic send_pixel(input logic [15:0] px, input logic [15:0] py);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Let the pipeline drain before a register write.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (rays_pending != 0)
            @(posedge clk);
        repeat (plu_pkg::LATENCY + 4) @(posedge clk);
    endtask

    // One register write; the caller drops cfg_valid after the last one.
    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_camera(input logic [31:0] ifx, input logic [31:0] ox,
                               input logic [31:0] ify, input logic [31:0] oy,
                               input logic [31:0] k1, input logic [31:0] k2,
                               input logic [31:0] p1, input logic [31:0] p2);
        drain();
        write_reg(plu_pkg::REG_INV_FOCAL_X, ifx);
        write_reg(plu_pkg::REG_OFFSET_X, ox);
        write_reg(plu_pkg::REG_INV_FOCAL_Y, ify);
        write_reg(plu_pkg::REG_OFFSET_Y, oy);
        write_reg(plu_pkg::REG_RADIAL_K1, k1);
        write_reg(plu_pkg::REG_RADIAL_K2, k2);
        write_reg(plu_pkg::REG_TANGENT_P1, p1);
        write_reg(plu_pkg::REG_TANGENT_P2, p2);
        cfg_valid <= 1'b0;
    endtask

    // Random pixels, mostly inside a normal frame, some anywhere.
    task automatic random_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                send_pixel(16'($urandom), 16'($urandom));
            else
                send_pixel(16'($urandom_range(640 * 16)), 16'($urandom_range(480 * 16)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: everything maps to the origin.
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h1234, 16'hABCD);

        // Typical lens: f = 500, center (320, 240), mild barrel distortion.
        load_camera(32'd8589935, -32'sd171798692, 32'd8589935, -32'sd128849019,
                    -32'sd75161928, 32'sd18790482, 32'sd53687, -32'sd53687);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0);
        send_pixel(16'd5120, 16'd3840);
        send_pixel(16'd10240, 16'd7680);
        send_pixel(16'd1, 16'd1);
        send_pixel(16'hAAAA, 16'h5555);
        send_pixel(16'h5555, 16'hAAAA);
        random_pixels(300);
        idle_pct = 83;
        random_pixels(200);
        idle_pct = 28;
        random_pixels(150);

        // Extreme registers: clipping everywhere.
        idle_pct = 0;
        load_camera(32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000,
                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        random_pixels(60);
        load_camera(32'd0, 32'h80000000, 32'd0, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        idle_pct = 28;
        random_pixels(60);

        // Random calibrations; indexes above seven must leave them alone.
        for (int n = 0; n < 4; n++)
        begin
            load_camera($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
            @(posedge clk);
            for (int j = 8; j < 16; j++)
                write_reg(4'(j), $urandom);
            cfg_valid <= 1'b0;
            idle_pct = (n % 2 == 0) ? 83 : 0;
            random_pixels(50);
        end

        // Wide lens, short focal length, strong distortion.
        load_camera(32'd42949673, -32'sd858993459, 32'd42949673, -32'sd644245094,
                    -32'sd107374182, 32'sd26843546, -32'sd268435, 32'sd536871);
        idle_pct = 0;
        random_pixels(150);
        idle_pct = 83;
        random_pixels(100);
        idle_pct = 28;
        random_pixels(100);

        drain();
        $display("Checked %0d rays over reset, typical, extreme, random and wide-lens",
                 rays_checked);
        $display("calibrations; %0d of them clipped.", rays_clipped);
        if (mismatches == 0 && rays_pending == 0)
            $display("tb_pinhole_lift_undistort_unit: clean");
        else
            $display("tb_pinhole_lift_undistort_unit: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_pinhole_lift_undistort_unit: errors");
        $finish;
    end
endmodule
`default_nettype wire

### pinhole_lift_undistort_unit.f
hdl/plu_pkg.sv
hdl/plu_lift.sv
hdl/plu_iter.sv
hdl/pinhole_lift_undistort_unit.sv
hdl/plu_checker.sv
bench/plu_checker.sv
bench/tb_pinhole_lift_undistort_unit.sv
